[sv/fblr_pkg.sv]
// ----------------------------------------------------------------------------
// fblr_pkg
// Shared types and constants of the framebuffer line rasterizer: operation
// and color codes, walker control, default geometry.
// ----------------------------------------------------------------------------
package fblr_pkg;

  // Default geometry and coordinate width
  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int COORD_BITS_DEF    = 12;

  // Fixed field widths
  localparam int OP_W         = 2;
  localparam int COLOR_W      = 2;
  localparam int BYTE_INDEX_W = 10;
  localparam int DATA_W       = 8;
  localparam int ROW_SEL_W    = 3;

  // Fill bytes for clear
  localparam logic [DATA_W-1:0] FILL_WHITE = 8'hFF;
  localparam logic [DATA_W-1:0] FILL_BLACK = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_PIXEL = 2'd1,
    OP_LINE  = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [COLOR_W-1:0] {
    COLOR_BLACK  = 2'd0,
    COLOR_WHITE  = 2'd1,
    COLOR_INVERT = 2'd2,
    COLOR_NONE   = 2'd3
  } color_e;

  // Commands from the sequencer to the line walker
  typedef struct packed {
    logic load;
    logic advance;
  } walk_ctrl_t;

endpackage

[sv/fblr_if.sv]
// ----------------------------------------------------------------------------
// fblr_if
// Valid/ready channels of the rasterizer: the request channel carrying one
// operation and the response channel carrying its result.
// ----------------------------------------------------------------------------
interface fblr_req_if #(
  parameter int COORD_BITS = fblr_pkg::COORD_BITS_DEF
);
  logic                                  valid;
  logic                                  ready;
  logic [fblr_pkg::OP_W-1:0]             op;
  logic signed [COORD_BITS-1:0]          start_x;
  logic signed [COORD_BITS-1:0]          start_y;
  logic signed [COORD_BITS-1:0]          end_x;
  logic signed [COORD_BITS-1:0]          end_y;
  logic [fblr_pkg::COLOR_W-1:0]          color;
  logic [fblr_pkg::BYTE_INDEX_W-1:0]     byte_index;

  modport source (
    output valid, op, start_x, start_y, end_x, end_y, color, byte_index,
    input  ready
  );
  modport sink (
    input  valid, op, start_x, start_y, end_x, end_y, color, byte_index,
    output ready
  );
endinterface

interface fblr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fblr_pkg::DATA_W-1:0]   read_data;
  logic [fblr_pkg::OP_W-1:0]     done_op;

  modport source (
    output valid, read_data, done_op,
    input  ready
  );
  modport sink (
    input  valid, read_data, done_op,
    output ready
  );
endinterface

[sv/fblr_ram.sv]
// ----------------------------------------------------------------------------
// fblr_ram
// Generic single-clock RAM: one write port, one read port, registered read
// data that holds while no read is issued.
// ----------------------------------------------------------------------------
module fblr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/fblr_walker.sv]
// ----------------------------------------------------------------------------
// fblr_walker
// Bresenham line walker: loads two endpoints, then moves one pixel per
// advance command using a single error update unit.
// ----------------------------------------------------------------------------
module fblr_walker #(
  parameter int COORD_BITS = fblr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fblr_pkg::walk_ctrl_t         ctrl_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic signed [COORD_BITS-1:0] pos_x_o,
  output logic signed [COORD_BITS-1:0] pos_y_o,
  output logic                         at_end_o
);

  localparam int DW = COORD_BITS + 1;  // endpoint difference
  localparam int EW = COORD_BITS + 3;  // error term

  localparam logic signed [COORD_BITS-1:0] STEP_POS = COORD_BITS'(1);
  localparam logic signed [COORD_BITS-1:0] STEP_NEG = {COORD_BITS{1'b1}};

  logic signed [COORD_BITS-1:0] walk_x_q, walk_x_d, walk_y_q, walk_y_d;
  logic signed [EW-1:0]         walk_err_q, walk_err_d;
  logic signed [COORD_BITS-1:0] end_x_q, end_y_q;
  logic signed [EW-1:0]         dx_q, dy_q;
  logic                         sx_neg_q, sy_neg_q;

  logic signed [DW-1:0] diff_x, diff_y, abs_x, abs_y;
  logic signed [EW-1:0] dx_ld, dy_ld;
  logic signed [EW:0]   e2;
  logic                 step_x, step_y;

  // Setup terms at load
  always_comb begin
    diff_x = DW'(end_x_i) - DW'(start_x_i);
    diff_y = DW'(end_y_i) - DW'(start_y_i);
    abs_x  = diff_x[DW-1] ? -diff_x : diff_x;
    abs_y  = diff_y[DW-1] ? -diff_y : diff_y;
    dx_ld  = EW'(abs_x);
    dy_ld  = -EW'(abs_y);
  end

  // One Bresenham step
  always_comb begin
    e2     = $signed({walk_err_q, 1'b0});
    step_x = e2 >= (EW + 1)'(dy_q);
    step_y = e2 <= (EW + 1)'(dx_q);
    walk_err_d = walk_err_q + (step_x ? dy_q : EW'(0)) + (step_y ? dx_q : EW'(0));
    walk_x_d   = step_x ? walk_x_q + (sx_neg_q ? STEP_NEG : STEP_POS) : walk_x_q;
    walk_y_d   = step_y ? walk_y_q + (sy_neg_q ? STEP_NEG : STEP_POS) : walk_y_q;
  end

  // Walk position and error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_x_q   <= '0;
      walk_y_q   <= '0;
      walk_err_q <= '0;
    end else if (ctrl_i.load) begin
      walk_x_q   <= start_x_i;
      walk_y_q   <= start_y_i;
      walk_err_q <= dx_ld + dy_ld;
    end else if (ctrl_i.advance) begin
      walk_x_q   <= walk_x_d;
      walk_y_q   <= walk_y_d;
      walk_err_q <= walk_err_d;
    end
  end

  // Line constants, held for the whole walk
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      end_x_q  <= end_x_i;
      end_y_q  <= end_y_i;
      dx_q     <= dx_ld;
      dy_q     <= dy_ld;
      sx_neg_q <= !(start_x_i < end_x_i);
      sy_neg_q <= !(start_y_i < end_y_i);
    end
  end

  assign pos_x_o  = walk_x_q;
  assign pos_y_o  = walk_y_q;
  assign at_end_o = (walk_x_q == end_x_q) && (walk_y_q == end_y_q);

endmodule

[sv/framebuffer_line_rasterizer_core.sv]
// ----------------------------------------------------------------------------
// framebuffer_line_rasterizer_core
// One-bit framebuffer of pages of vertical bytes with clear, pixel, line
// and byte read operations.
//
// Usage:
//   req_i carries one operation per request (op, endpoints, color,
//   byte_index); rsp_o returns exactly one response per request with
//   done_op echoing op and read_data holding the byte for a read (zero
//   otherwise). A request is taken only while the sequencer is idle.
//   A read goes straight to the response state. A pixel or a line does
//   one RAM read and one RAM write per pixel that is written, and skips
//   pixels that are off screen or carry the no-effect color; a clear
//   writes one RAM word per cycle. After reset the block sweeps the whole
//   RAM to zero, one byte per cycle, with ready low. The speed of a line
//   is set by the read-modify-write on the single framebuffer RAM port pair.
//   The response sits in an output register; while the receiver stalls a
//   new request is still taken, and the next response waits in the
//   sequencer until the output register frees up.
// ----------------------------------------------------------------------------
module framebuffer_line_rasterizer_core #(
  parameter int SCREEN_WIDTH  = fblr_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = fblr_pkg::SCREEN_HEIGHT_DEF,
  parameter int COORD_BITS    = fblr_pkg::COORD_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fblr_req_if.sink     req_i,
  fblr_rsp_if.source   rsp_o
);

  localparam int NUM_PAGES  = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH      = SCREEN_WIDTH * NUM_PAGES;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int DATA_W     = fblr_pkg::DATA_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_CLEAR  = 5'b00010,
    ST_PIX_RD = 5'b00100,
    ST_PIX_WR = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [ADDR_W-1:0]   sweep_q, sweep_d;
  logic [DATA_W-1:0]   fill_q, fill_d;
  logic                emit_q, emit_d;
  fblr_pkg::op_e       op_q, op_d;
  fblr_pkg::color_e    color_q, color_d;
  logic                rd_hit_q, rd_hit_d;

  logic                out_valid_q, out_valid_d;
  logic [DATA_W-1:0]   out_data_q, out_data_d;
  fblr_pkg::op_e       out_op_q, out_op_d;

  logic                accept, slot_free;
  fblr_pkg::op_e       req_op;
  fblr_pkg::color_e    req_color;

  // Walker
  fblr_pkg::walk_ctrl_t         walk_ctrl;
  logic signed [COORD_BITS-1:0] walk_end_x, walk_end_y, pos_x, pos_y;
  logic                         at_end;

  // RAM ports
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  // Pixel addressing
  logic signed [31:0]        px, py, pix_addr_full;
  logic                      on_screen;
  logic [ADDR_W-1:0]         pix_addr;
  logic [DATA_W-1:0]         pix_mask, pix_byte;
  logic [31:0]               bi_ext;
  logic                      bi_in_range;

  assign accept    = req_i.valid && req_i.ready;
  assign slot_free = !out_valid_q || rsp_o.ready;
  assign req_op    = fblr_pkg::op_e'(req_i.op);
  assign req_color = fblr_pkg::color_e'(req_i.color);

  // A pixel is a line whose end is its start
  assign walk_end_x = (req_op == fblr_pkg::OP_LINE) ? req_i.end_x : req_i.start_x;
  assign walk_end_y = (req_op == fblr_pkg::OP_LINE) ? req_i.end_y : req_i.start_y;

  fblr_walker #(
    .COORD_BITS (COORD_BITS)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (walk_ctrl),
    .start_x_i (req_i.start_x),
    .start_y_i (req_i.start_y),
    .end_x_i   (walk_end_x),
    .end_y_i   (walk_end_y),
    .pos_x_o   (pos_x),
    .pos_y_o   (pos_y),
    .at_end_o  (at_end)
  );

  fblr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Screen check, byte address and bit mask of the walk position
  always_comb begin
    px            = 32'(pos_x);
    py            = 32'(pos_y);
    on_screen     = (px >= 0) && (px < SCREEN_WIDTH) && (py >= 0) && (py < SCREEN_HEIGHT);
    pix_addr_full = px + (py >>> 3) * SCREEN_WIDTH;
    pix_addr      = pix_addr_full[ADDR_W-1:0];
    pix_mask      = DATA_W'(1) << pos_y[fblr_pkg::ROW_SEL_W-1:0];
    unique case (color_q)
      fblr_pkg::COLOR_WHITE:  pix_byte = ram_rdata | pix_mask;
      fblr_pkg::COLOR_BLACK:  pix_byte = ram_rdata & ~pix_mask;
      fblr_pkg::COLOR_INVERT: pix_byte = ram_rdata ^ pix_mask;
      fblr_pkg::COLOR_NONE:   pix_byte = ram_rdata;
      default:                pix_byte = ram_rdata;
    endcase
  end

  assign bi_ext      = 32'(req_i.byte_index);
  assign bi_in_range = bi_ext < 32'(DEPTH);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    sweep_d     = sweep_q;
    fill_d      = fill_q;
    emit_d      = emit_q;
    op_d        = op_q;
    color_d     = color_q;
    rd_hit_d    = rd_hit_q;
    walk_ctrl   = '0;
    ram_we      = 1'b0;
    ram_waddr   = pix_addr;
    ram_wdata   = pix_byte;
    ram_re      = 1'b0;
    ram_raddr   = pix_addr;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_data_d  = out_data_q;
    out_op_d    = out_op_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d     = req_op;
          color_d  = req_color;
          rd_hit_d = 1'b0;
          unique case (req_op)
            fblr_pkg::OP_CLEAR: begin
              fill_d  = (req_color == fblr_pkg::COLOR_WHITE) ? fblr_pkg::FILL_WHITE
                                                             : fblr_pkg::FILL_BLACK;
              sweep_d = '0;
              emit_d  = 1'b1;
              state_d = ST_CLEAR;
            end
            fblr_pkg::OP_PIXEL, fblr_pkg::OP_LINE: begin
              walk_ctrl.load = 1'b1;
              state_d        = ST_PIX_RD;
            end
            fblr_pkg::OP_READ: begin
              ram_re    = bi_in_range;
              ram_raddr = bi_ext[ADDR_W-1:0];
              rd_hit_d  = bi_in_range;
              state_d   = ST_RESP;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = fill_q;
        sweep_d   = sweep_q + 1'b1;
        if (sweep_q == ADDR_W'(DEPTH - 1)) begin
          state_d = emit_q ? ST_RESP : ST_IDLE;
        end
      end
      ST_PIX_RD: begin
        if (on_screen && (color_q != fblr_pkg::COLOR_NONE)) begin
          ram_re  = 1'b1;
          state_d = ST_PIX_WR;
        end else if (at_end) begin
          state_d = ST_RESP;
        end else begin
          walk_ctrl.advance = 1'b1;
        end
      end
      ST_PIX_WR: begin
        ram_we = 1'b1;
        if (at_end) begin
          state_d = ST_RESP;
        end else begin
          walk_ctrl.advance = 1'b1;
          state_d           = ST_PIX_RD;
        end
      end
      ST_RESP: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_data_d  = rd_hit_q ? ram_rdata : '0;
          out_op_d    = op_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control state; reset starts the zeroing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      sweep_q     <= '0;
      fill_q      <= fblr_pkg::FILL_BLACK;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      fill_q      <= fill_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and response payload
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    color_q    <= color_d;
    rd_hit_q   <= rd_hit_d;
    out_data_q <= out_data_d;
    out_op_q   <= out_op_d;
  end

  assign req_i.ready     = (state_q == ST_IDLE);
  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;
  assign rsp_o.done_op   = out_op_q;

`ifndef SYNTHESIS
  // Only reads return data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid && (rsp_o.done_op != fblr_pkg::OP_READ) |-> rsp_o.read_data == '0)
    else $error("nonzero read_data on a non-read response");

  // Busy right after a request is taken
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_i.ready)
    else $error("ready held high after a request was taken");

  // No pixel write for the no-effect color
  a_no_write_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIX_WR) |-> (color_q != fblr_pkg::COLOR_NONE))
    else $error("pixel write issued with no-effect color");

  // Clear sweep visits every address in order
  a_sweep_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) && ($past(state_q) == ST_CLEAR) && $past(rst_ni)
      |-> sweep_q == $past(sweep_q) + 1'b1)
    else $error("clear sweep skipped an address");
`endif

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the framebuffer line rasterizer. Clear, pixel,
// line and read requests are sent through the request channel. A local
// copy of the framebuffer predicts every response, and each response is
// checked against the oldest prediction. Requests go out in random bursts.
// The response side stalls on a changing mask.
// ----------------------------------------------------------------------------
module tb;

  localparam int SCR_W      = fblr_pkg::SCREEN_WIDTH_DEF;
  localparam int SCR_H      = fblr_pkg::SCREEN_HEIGHT_DEF;
  localparam int PAGES      = (SCR_H + 7) / 8;
  localparam int FB_BYTES   = SCR_W * PAGES;
  localparam int COORD_W    = fblr_pkg::COORD_BITS_DEF;
  localparam int COORD_SPAN = 1 << COORD_W;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    fblr_pkg::op_e                     op;
    coord_t                            x0;
    coord_t                            y0;
    coord_t                            x1;
    coord_t                            y1;
    fblr_pkg::color_e                  color;
    logic [fblr_pkg::BYTE_INDEX_W-1:0] byte_index;
  } raster_cmd_t;

  typedef struct {
    logic [fblr_pkg::DATA_W-1:0] read_data;
    fblr_pkg::op_e               done_op;
  } raster_reply_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   reply_ready;

  fblr_req_if req_ch ();
  fblr_rsp_if rsp_ch ();

  assign rsp_ch.ready = reply_ready;

  framebuffer_line_rasterizer_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  // Local copy of the framebuffer and the pending responses
  logic [fblr_pkg::DATA_W-1:0] frame_bytes [FB_BYTES];
  raster_reply_t               expected_replies [$];

  int mismatch_count;
  int replies_checked;
  int op_count [4];
  int burst_left;
  bit steady_send;

  // --------------------------------------------------------------------------
  // Framebuffer predictor
  // --------------------------------------------------------------------------
  function automatic void fb_plot(int x, int y, fblr_pkg::color_e color);
    int idx;
    logic [fblr_pkg::DATA_W-1:0] mask;
    if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) return;
    idx  = x + (y / 8) * SCR_W;
    mask = 8'd1 << (y % 8);
    case (color)
      fblr_pkg::COLOR_WHITE:  frame_bytes[idx] = frame_bytes[idx] | mask;
      fblr_pkg::COLOR_BLACK:  frame_bytes[idx] = frame_bytes[idx] & ~mask;
      fblr_pkg::COLOR_INVERT: frame_bytes[idx] = frame_bytes[idx] ^ mask;
      default: ;
    endcase
  endfunction

  // Integer Bresenham walk, both octant families in one loop
  function automatic void fb_line(int x0, int y0, int x1, int y1,
                                  fblr_pkg::color_e color);
    int dx, dy, sx, sy, err, e2, wx, wy;
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = (y1 > y0) ? y0 - y1 : y1 - y0;
    sx  = (x0 < x1) ? 1 : -1;
    sy  = (y0 < y1) ? 1 : -1;
    wx  = x0;
    wy  = y0;
    err = dx + dy;
    forever begin
      fb_plot(wx, wy, color);
      if (wx == x1 && wy == y1) break;
      e2 = 2 * err;
      if (e2 >= dy) begin
        err += dy;
        wx  += sx;
      end
      if (e2 <= dx) begin
        err += dx;
        wy  += sy;
      end
    end
  endfunction

  function automatic raster_reply_t predict_reply(raster_cmd_t cmd);
    raster_reply_t rep;
    rep.read_data = '0;
    rep.done_op   = cmd.op;
    case (cmd.op)
      fblr_pkg::OP_CLEAR: begin
        foreach (frame_bytes[i])
          frame_bytes[i] = (cmd.color == fblr_pkg::COLOR_WHITE) ? fblr_pkg::FILL_WHITE
                                                                : fblr_pkg::FILL_BLACK;
      end
      fblr_pkg::OP_PIXEL: fb_plot(int'(cmd.x0), int'(cmd.y0), cmd.color);
      fblr_pkg::OP_LINE:  fb_line(int'(cmd.x0), int'(cmd.y0), int'(cmd.x1), int'(cmd.y1),
                                  cmd.color);
      default: begin
        if (cmd.byte_index < FB_BYTES) rep.read_data = frame_bytes[cmd.byte_index];
      end
    endcase
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Clock, timeout
  // --------------------------------------------------------------------------
  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("Timeout with %0d responses outstanding", expected_replies.size());
    $display("Mismatches found");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Response side: ready follows a random mask that is replaced now and then
  // --------------------------------------------------------------------------
  logic [15:0] stall_tick = '0;
  logic [15:0] stall_mask = '1;

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 16'd1;
    if (stall_tick[8:0] == '0)
      stall_mask <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    reply_ready <= stall_mask[stall_tick[3:0]];
  end

  task automatic note_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $time, msg);
  endtask

  // Compare each accepted response with the oldest prediction
  always @(posedge clk_i) begin
    raster_reply_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      replies_checked++;
      if (expected_replies.size() == 0) begin
        note_mismatch($sformatf("unexpected response done_op=%0d read_data=%02h",
                                rsp_ch.done_op, rsp_ch.read_data));
      end else begin
        want = expected_replies.pop_front();
        if (rsp_ch.done_op !== want.done_op)
          note_mismatch($sformatf("done_op: expected %0d, got %0d",
                                  want.done_op, rsp_ch.done_op));
        if (rsp_ch.read_data !== want.read_data)
          note_mismatch($sformatf("read_data (op %0d): expected %02h, got %02h",
                                  want.done_op, want.read_data, rsp_ch.read_data));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Request side: one request per call, bursts separated by random gaps
  // --------------------------------------------------------------------------
  task automatic send_request(fblr_pkg::op_e op, int x0, int y0, int x1, int y1,
                              fblr_pkg::color_e color, int byte_index);
    raster_cmd_t cmd;
    int          gap;
    cmd.op         = op;
    cmd.x0         = coord_t'(x0);
    cmd.y0         = coord_t'(y0);
    cmd.x1         = coord_t'(x1);
    cmd.y1         = coord_t'(y1);
    cmd.color      = color;
    cmd.byte_index = fblr_pkg::BYTE_INDEX_W'(byte_index);
    if (burst_left <= 0) begin
      gap        = steady_send ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= cmd.op;
    req_ch.start_x    <= cmd.x0;
    req_ch.start_y    <= cmd.y0;
    req_ch.end_x      <= cmd.x1;
    req_ch.end_y      <= cmd.y1;
    req_ch.color      <= cmd.color;
    req_ch.byte_index <= cmd.byte_index;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    burst_left--;
    op_count[cmd.op]++;
    expected_replies.push_back(predict_reply(cmd));
  endtask

  // Stimulus helpers
  function automatic int near_coord(int span);
    return int'($urandom_range(0, span + 15)) - 8;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, COORD_SPAN - 1)) - COORD_SPAN / 2;
  endfunction

  function automatic fblr_pkg::color_e pick_color();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return fblr_pkg::COLOR_WHITE;
    if (r < 65) return fblr_pkg::COLOR_INVERT;
    if (r < 90) return fblr_pkg::COLOR_BLACK;
    return fblr_pkg::COLOR_NONE;
  endfunction

  function automatic fblr_pkg::color_e any_color();
    return fblr_pkg::color_e'($urandom_range(0, 3));
  endfunction

  // Byte that holds pixel (x, y), or a random byte when it is off screen
  function automatic int byte_at(int x, int y);
    if (x < 0 || x >= SCR_W || y < 0 || y >= SCR_H) return $urandom_range(0, FB_BYTES - 1);
    return x + (y / 8) * SCR_W;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_directed();
    steady_send = 1'b1;
    send_request(fblr_pkg::OP_READ,  0, 0, 0, 0, fblr_pkg::COLOR_BLACK, 0);
    send_request(fblr_pkg::OP_READ,  0, 0, 0, 0, fblr_pkg::COLOR_BLACK, FB_BYTES - 1);
    send_request(fblr_pkg::OP_PIXEL, 0, 0, 0, 0, fblr_pkg::COLOR_WHITE, 0);
    send_request(fblr_pkg::OP_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, fblr_pkg::COLOR_WHITE, 0);
    // Off-screen pixels, one edge each plus the coordinate extremes
    send_request(fblr_pkg::OP_PIXEL, -1, 5, 0, 0, fblr_pkg::COLOR_WHITE, 0);
    send_request(fblr_pkg::OP_PIXEL, SCR_W, 5, 0, 0, fblr_pkg::COLOR_WHITE, 0);
    send_request(fblr_pkg::OP_PIXEL, 5, SCR_H, 0, 0, fblr_pkg::COLOR_WHITE, 0);
    send_request(fblr_pkg::OP_PIXEL, -2048, 2047, 0, 0, fblr_pkg::COLOR_WHITE, 0);
    send_request(fblr_pkg::OP_PIXEL, 0, 0, 0, 0, fblr_pkg::COLOR_INVERT, 0);
    send_request(fblr_pkg::OP_PIXEL, 1, 0, 0, 0, fblr_pkg::COLOR_INVERT, 0);
    send_request(fblr_pkg::OP_PIXEL, 2, 0, 0, 0, fblr_pkg::COLOR_NONE, 0);
    send_request(fblr_pkg::OP_PIXEL, SCR_W - 1, SCR_H - 1, 0, 0, fblr_pkg::COLOR_BLACK, 0);
    send_request(fblr_pkg::OP_READ,  0, 0, 0, 0, fblr_pkg::COLOR_BLACK, 0);
    send_request(fblr_pkg::OP_READ,  0, 0, 0, 0, fblr_pkg::COLOR_BLACK, FB_BYTES - 1);
    // Degenerate, shallow, steep reversed and full-range diagonal lines
    send_request(fblr_pkg::OP_LINE, 10, 10, 10, 10, fblr_pkg::COLOR_WHITE, 0);
    send_request(fblr_pkg::OP_LINE, 0, 20, SCR_W - 1, 30, fblr_pkg::COLOR_WHITE, 0);
    send_request(fblr_pkg::OP_LINE, 100, SCR_H - 1, 90, 0, fblr_pkg::COLOR_INVERT, 0);
    send_request(fblr_pkg::OP_LINE, -2048, -2048, 2047, 2047, fblr_pkg::COLOR_WHITE, 0);
    send_request(fblr_pkg::OP_LINE, 2047, -2048, -2048, 2047, fblr_pkg::COLOR_NONE, 0);
    send_request(fblr_pkg::OP_READ, 0, 0, 0, 0, fblr_pkg::COLOR_BLACK, 2 * SCR_W + 64);
    send_request(fblr_pkg::OP_READ, 0, 0, 0, 0, fblr_pkg::COLOR_BLACK, 1 * SCR_W + 10);
    // Clear in every color; only white fills ones
    send_request(fblr_pkg::OP_CLEAR, 0, 0, 0, 0, fblr_pkg::COLOR_WHITE, 0);
    send_request(fblr_pkg::OP_READ,  0, 0, 0, 0, fblr_pkg::COLOR_BLACK, 517);
    send_request(fblr_pkg::OP_CLEAR, 0, 0, 0, 0, fblr_pkg::COLOR_INVERT, 0);
    send_request(fblr_pkg::OP_READ,  0, 0, 0, 0, fblr_pkg::COLOR_BLACK, 517);
    send_request(fblr_pkg::OP_CLEAR, 0, 0, 0, 0, fblr_pkg::COLOR_NONE, 0);
    send_request(fblr_pkg::OP_CLEAR, 0, 0, 0, 0, fblr_pkg::COLOR_BLACK, 0);
  endtask

  task automatic test_pixels(int count);
    int x, y;
    steady_send = 1'b0;
    for (int i = 0; i < count; i++) begin
      x = near_coord(SCR_W);
      y = near_coord(SCR_H);
      if ($urandom_range(0, 9) == 0) begin
        x = any_coord();
        y = any_coord();
      end
      if ($urandom_range(0, 99) < 60)
        send_request(fblr_pkg::OP_PIXEL, x, y, any_coord(), any_coord(), pick_color(),
                     $urandom_range(0, FB_BYTES - 1));
      else
        send_request(fblr_pkg::OP_READ, x, y, any_coord(), any_coord(), any_color(),
                     byte_at(x, y));
    end
  endtask

  task automatic test_lines(int count);
    int x0, y0, x1, y1, r;
    for (int i = 0; i < count; i++) begin
      steady_send = (i < count / 4);
      // Start from a fresh buffer now and then so that reads stay informative
      if (i % 120 == 0) begin
        send_request(fblr_pkg::OP_CLEAR, any_coord(), any_coord(), any_coord(), any_coord(),
                     ($urandom_range(0, 1) == 0) ? fblr_pkg::COLOR_WHITE
                                                 : fblr_pkg::COLOR_BLACK,
                     $urandom_range(0, FB_BYTES - 1));
        continue;
      end
      x0 = near_coord(SCR_W);
      y0 = near_coord(SCR_H);
      x1 = near_coord(SCR_W);
      y1 = near_coord(SCR_H);
      r  = $urandom_range(0, 99);
      if (r < 6) begin
        x0 = any_coord();
        y0 = any_coord();
        x1 = any_coord();
        y1 = any_coord();
      end else if (r < 14) begin
        x1 = int'($urandom_range(0, 255)) - 64;
        y1 = int'($urandom_range(0, 191)) - 64;
      end else if (r < 20) begin
        x1 = x0;
        y1 = y0;
      end
      if ($urandom_range(0, 1) == 0)
        send_request(fblr_pkg::OP_LINE, x0, y0, x1, y1, pick_color(),
                     $urandom_range(0, FB_BYTES - 1));
      else
        send_request(fblr_pkg::OP_READ, x0, y0, x1, y1, pick_color(), byte_at(x0, y0));
      if ($urandom_range(0, 1) == 0)
        send_request(fblr_pkg::OP_READ, 0, 0, 0, 0, fblr_pkg::COLOR_BLACK, byte_at(x1, y1));
    end
  endtask

  task automatic test_mixed(int count);
    int x0, y0, x1, y1, r;
    for (int i = 0; i < count; i++) begin
      steady_send = (i >= count / 2 && i < count / 2 + 60);
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) begin
        x0 = any_coord();
        y0 = any_coord();
        x1 = any_coord();
        y1 = any_coord();
      end else begin
        x0 = near_coord(SCR_W);
        y0 = near_coord(SCR_H);
        x1 = near_coord(SCR_W);
        y1 = near_coord(SCR_H);
      end
      if (r < 2)
        send_request(fblr_pkg::OP_CLEAR, x0, y0, x1, y1, any_color(),
                     $urandom_range(0, FB_BYTES - 1));
      else if (r < 32)
        send_request(fblr_pkg::OP_PIXEL, x0, y0, x1, y1, any_color(),
                     $urandom_range(0, FB_BYTES - 1));
      else if (r < 60)
        send_request(fblr_pkg::OP_LINE, x0, y0, x1, y1, any_color(),
                     $urandom_range(0, FB_BYTES - 1));
      else
        send_request(fblr_pkg::OP_READ, x0, y0, x1, y1, any_color(),
                     ($urandom_range(0, 1) == 0) ? byte_at(x0, y0)
                                                 : $urandom_range(0, FB_BYTES - 1));
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    foreach (frame_bytes[i]) frame_bytes[i] = '0;
    req_ch.valid      <= 1'b0;
    req_ch.op         <= fblr_pkg::OP_CLEAR;
    req_ch.start_x    <= '0;
    req_ch.start_y    <= '0;
    req_ch.end_x      <= '0;
    req_ch.end_y      <= '0;
    req_ch.color      <= fblr_pkg::COLOR_BLACK;
    req_ch.byte_index <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_pixels(300);
    test_lines(280);
    test_mixed(380);

    req_ch.valid <= 1'b0;
    waited = 0;
    while (expected_replies.size() != 0 && waited < 200_000) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_replies.size() != 0) begin
      $display("%0d responses never arrived", expected_replies.size());
      mismatch_count += expected_replies.size();
    end
    repeat (64) @(posedge clk_i);

    $display("Sent %0d clears, %0d pixels, %0d lines and %0d reads",
             op_count[fblr_pkg::OP_CLEAR], op_count[fblr_pkg::OP_PIXEL],
             op_count[fblr_pkg::OP_LINE], op_count[fblr_pkg::OP_READ]);
    $display("Checked %0d responses, %0d mismatches", replies_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
